// ===== rtl/three_tap_pitch_shifter_defines.svh =====
// assertion macros for the pitch shifter
`ifndef THREE_TAP_PITCH_SHIFTER_DEFINES_SVH
`define THREE_TAP_PITCH_SHIFTER_DEFINES_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define TPSH_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// condition implies consequence in the next cycle
`define TPSH_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`else
`define TPSH_ASSERT_SAME(label, clk, rst, cond, cons, msg)
`define TPSH_ASSERT_NEXT(label, clk, rst, cond, cons, msg)
`endif

`endif

// ===== rtl/tpsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpsh_pkg;

   localparam int STORE_DEPTH      = 4096;
   localparam int STORE_AW         = $clog2(STORE_DEPTH);
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int QUARTER_DEPTH    = SINE_TABLE_DEPTH / 4;
   localparam int QUARTER_AW       = $clog2(QUARTER_DEPTH);
   localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
   localparam int FIFO_DEPTH       = 2;

   localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1846;
   localparam logic [63:0] HALF_LSB15  = 64'h0000100000000000;

   localparam logic [0:0] CSR_PITCH = 1'b0;
   localparam logic [0:0] CSR_WET   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_READ, ST_MUL, ST_ACC, ST_MIX, ST_OUT
   } tpsh_state_type;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] sample;
   } tpsh_queue_type;

   typedef logic [14:0] qsine_table_type [QUARTER_DEPTH];

   function automatic logic [31:0] pitch_step(input logic [2:0] sel);
      logic [31:0] step;
      case (sel)
         3'd0:    step = 32'h00080000;
         3'd1:    step = 32'h000AAAAA;
         3'd2:    step = 32'h000C0000;
         3'd3:    step = 32'h00100000;
         3'd4:    step = 32'h00155555;
         3'd5:    step = 32'h00180000;
         default: step = 32'h00200000;
      endcase
      return step;
   endfunction

   // (a * b) >> 60, elaboration use only
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
      al  = {32'd0, a[31:0]};
      ah  = {32'd0, a[63:32]};
      bl  = {32'd0, b[31:0]};
      bh  = {32'd0, b[63:32]};
      ll  = al * bl;
      lh  = al * bh;
      hl  = ah * bl;
      hh  = ah * bh;
      mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
      lo  = {mid[31:0], ll[31:0]};
      hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
      return {hi[59:0], lo[63:60]};
   endfunction

   // q15 sin(m/16384 * pi/2) by taylor series
   function automatic logic [14:0] quarter_sine(input logic [14:0] m);
      logic [63:0] x, x2, term, sum, r;
      x    = (PI_HALF_Q60 >> 14) * {49'd0, m};
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
      term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd110; sum = sum - term;
      term = mul_q60(term, x2) / 64'd156; sum = sum + term;
      term = mul_q60(term, x2) / 64'd210; sum = sum - term;
      term = mul_q60(term, x2) / 64'd272; sum = sum + term;
      term = mul_q60(term, x2) / 64'd342; sum = sum - term;
      term = mul_q60(term, x2) / 64'd420; sum = sum + term;
      term = mul_q60(term, x2) / 64'd506; sum = sum - term;
      term = mul_q60(term, x2) / 64'd600; sum = sum + term;
      r = (sum + HALF_LSB15) >> 45;
      return (r > 64'd32767) ? 15'd32767 : r[14:0];
   endfunction

   function automatic qsine_table_type build_qsine();
      qsine_table_type tbl;
      for (int j = 0; j < QUARTER_DEPTH; j++) begin
         tbl[j] = quarter_sine(15'((j * 16384) / QUARTER_DEPTH));
      end
      return tbl;
   endfunction

   localparam qsine_table_type QSINE = build_qsine();

   // q15 sine of a 16-bit angle, quarter-wave table with symmetry
   function automatic logic signed [15:0] sine_of(input logic [15:0] angle);
      logic [SINE_AW-1:0]  k;
      logic [1:0]          quad;
      logic [QUARTER_AW:0] j;
      logic [14:0]         mag;
      k    = angle[15 -: SINE_AW];
      quad = k[SINE_AW-1 -: 2];
      j    = {1'b0, k[QUARTER_AW-1:0]};
      if (quad[0]) begin
         j = (QUARTER_AW + 1)'(QUARTER_DEPTH) - j;
      end
      mag = j[QUARTER_AW] ? 15'd32767 : QSINE[j[QUARTER_AW-1:0]];
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage
`default_nettype wire

// ===== rtl/three_tap_pitch_shifter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | beat fields (lsb up)             | accepted when
// req_      | in  | tdata: sample_in[15:0]           | req_tvalid & req_tready
// rsp_      | out | tdata: sample_out[15:0]          | rsp_tvalid & rsp_tready
// csr_      | in  | index 0 pitch_select, 1 wet_mix  | csr_valid & csr_ready
//
// in the back end each sample is taken from the queue, written to the store,
// then three taps are read through the single store port, each by a read,
// a multiply and an add, then the result is mixed and output; the shared store
// port and one tap multiplier make the taps run in turn; the output step waits
// while the result register still holds an untaken beat
// reset is synchronous; the delay line needs no clearing pass, a fill count
// makes never-written entries read as zero
// a two-beat queue lets the input keep taking samples while the back end
// works or waits on a stalled result register
module three_tap_pitch_shifter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // sample_in[15:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // sample_out[15:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [14:0] csr_data
);
   logic [2:0]  pitch_ff;
   logic [14:0] wet_ff;
   logic        pop;
   tpsh_pkg::tpsh_queue_type head;

   // config registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= 3'd3;
         wet_ff   <= 15'd0;
      end else if (csr_valid) begin
         case (csr_index)
            tpsh_pkg::CSR_PITCH: pitch_ff <= csr_data[2:0];
            tpsh_pkg::CSR_WET:   wet_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // front: input queue
   tpsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head)
   );

   // back: delay line, taps and mix
   tpsh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .pitch_select (pitch_ff),
      .wet_mix      (wet_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== rtl/tpsh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/tpsh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "three_tap_pitch_shifter_defines.svh"
module tpsh_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [15:0]             req_tdata,
   input  wire logic                    pop,
   output tpsh_pkg::tpsh_queue_type     head
);
   logic [15:0] slot_ff [tpsh_pkg::FIFO_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop_ok;

   // two-entry sample queue
   assign req_tready = (count_ff != 2'(tpsh_pkg::FIFO_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop_ok     = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata;
      end
   end

   assign head.valid  = (count_ff != 2'd0);
   assign head.sample = $signed(slot_ff[rd_ptr_ff]);

   `TPSH_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2, "queue overfull")
   `TPSH_ASSERT_NEXT(a_push_only, clock, reset, push && !pop_ok, count_ff == $past(count_ff) + 2'd1, "queue count lost a push")
endmodule
`default_nettype wire

// ===== rtl/tpsh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "three_tap_pitch_shifter_defines.svh"
module tpsh_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tpsh_pkg::tpsh_queue_type   head,
   output logic                            pop,
   input  wire logic [2:0]                 pitch_select,
   input  wire logic [14:0]                wet_mix,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata
);
   tpsh_pkg::tpsh_state_type state_ff, state_in;

   logic [31:0]                   acc_ff [3];
   logic [tpsh_pkg::STORE_AW-1:0] wp_ff;
   logic [tpsh_pkg::STORE_AW:0]   fill_ff;
   logic [1:0]                    idx_ff;
   logic signed [15:0]            dry_ff, g_ff, v_ff;
   logic signed [31:0]            prod_ff;
   logic signed [18:0]            sum_ff;
   logic signed [33:0]            p1_ff;
   logic signed [31:0]            p2_ff;
   logic                          tap_ok_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_data_ff;

   logic                          ram_we;
   logic [tpsh_pkg::STORE_AW-1:0] ram_addr;
   logic [15:0]                   ram_rdata;
   logic [31:0]                   step;
   logic [31:0]                   acc_cur;
   logic [tpsh_pkg::STORE_AW-1:0] tap_addr;
   logic                          tap_ok;
   logic                          out_free;
   logic signed [18:0]            tap_term;
   logic signed [17:0]            wet;
   logic [14:0]                   dry_w;
   logic signed [19:0]            mixed;
   logic [15:0]                   clamped;

   assign step     = tpsh_pkg::pitch_step(pitch_select);
   assign acc_cur  = acc_ff[idx_ff];
   assign tap_addr = acc_cur[31 -: tpsh_pkg::STORE_AW];
   assign tap_ok   = fill_ff[tpsh_pkg::STORE_AW] ||
                     (tap_addr < fill_ff[tpsh_pkg::STORE_AW-1:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign tap_term = 19'(v_ff >>> 1) + 19'(prod_ff >>> 16);
   assign wet      = sum_ff[18:1];
   assign dry_w    = 15'd32767 - wet_mix;
   assign mixed    = 20'(p1_ff >>> 15) + 20'(p2_ff >>> 15);

   always_comb begin
      if (mixed > 20'sd32767) begin
         clamped = 16'h7FFF;
      end else if (mixed < -20'sd32767) begin
         clamped = 16'h8001;
      end else begin
         clamped = mixed[15:0];
      end
   end

   // result register: load on the output cycle, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == tpsh_pkg::ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpsh_pkg::ST_IDLE:  if (head.valid) state_in = tpsh_pkg::ST_WRITE;
         tpsh_pkg::ST_WRITE: state_in = tpsh_pkg::ST_READ;
         tpsh_pkg::ST_READ:  state_in = tpsh_pkg::ST_MUL;
         tpsh_pkg::ST_MUL:   state_in = tpsh_pkg::ST_ACC;
         tpsh_pkg::ST_ACC:   state_in = (idx_ff == 2'd2) ? tpsh_pkg::ST_MIX : tpsh_pkg::ST_READ;
         tpsh_pkg::ST_MIX:   state_in = tpsh_pkg::ST_OUT;
         tpsh_pkg::ST_OUT:   if (out_free) state_in = tpsh_pkg::ST_IDLE;
         default:            state_in = tpsh_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      ram_we   = 1'b0;
      ram_addr = tap_addr;
      case (state_ff)
         tpsh_pkg::ST_IDLE:  pop = head.valid;
         tpsh_pkg::ST_WRITE: begin
            ram_we   = 1'b1;
            ram_addr = wp_ff;
         end
         default:  ram_addr = tap_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpsh_pkg::ST_IDLE;
         acc_ff[0]    <= 32'h00000000;
         acc_ff[1]    <= 32'h55555555;
         acc_ff[2]    <= 32'hAAAAAAAA;
         wp_ff        <= '0;
         fill_ff      <= '0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            tpsh_pkg::ST_WRITE: begin
               for (int i = 0; i < 3; i++) begin
                  acc_ff[i] <= acc_ff[i] + step;
               end
               wp_ff  <= wp_ff + 1'b1;
               idx_ff <= 2'd0;
               if (!fill_ff[tpsh_pkg::STORE_AW]) begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
            tpsh_pkg::ST_ACC: if (idx_ff != 2'd2) idx_ff <= idx_ff + 2'd1;
            default: ;
         endcase
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      case (state_ff)
         tpsh_pkg::ST_IDLE:  if (head.valid) dry_ff <= head.sample;
         tpsh_pkg::ST_WRITE: sum_ff <= '0;
         tpsh_pkg::ST_READ: begin
            g_ff      <= tpsh_pkg::sine_of(acc_cur[31:16] - 16'd16384);
            tap_ok_ff <= tap_ok;
         end
         tpsh_pkg::ST_MUL: begin
            v_ff    <= tap_ok_ff ? $signed(ram_rdata) : 16'sd0;
            prod_ff <= (tap_ok_ff ? $signed(ram_rdata) : 16'sd0) * g_ff;
         end
         tpsh_pkg::ST_ACC: sum_ff <= sum_ff + tap_term;
         tpsh_pkg::ST_MIX: begin
            p1_ff <= wet * $signed({1'b0, wet_mix});
            p2_ff <= $signed({1'b0, dry_w}) * dry_ff;
         end
         tpsh_pkg::ST_OUT: if (out_free) rsp_data_ff <= clamped;
         default: ;
      endcase
   end

   tpsh_ram #(.WIDTH(16), .DEPTH(tpsh_pkg::STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (dry_ff),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TPSH_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= 13'(tpsh_pkg::STORE_DEPTH), "fill count past store depth")
   `TPSH_ASSERT_SAME(a_idx_bound, clock, reset, 1'b1, idx_ff <= 2'd2, "tap index out of range")
   `TPSH_ASSERT_NEXT(a_pop_starts, clock, reset, pop, state_ff == tpsh_pkg::ST_WRITE, "pop without starting item")
   `TPSH_ASSERT_SAME(a_fill_tracks_wp, clock, reset, !fill_ff[tpsh_pkg::STORE_AW], fill_ff[tpsh_pkg::STORE_AW-1:0] == wp_ff, "fill count and write pointer apart")
endmodule
`default_nettype wire
